/* rtl/page_frame_bitmap_allocator_assert.svh */
// Assertion macros shared by the page frame bitmap allocator RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pfba_pkg.sv */
// Shared types, command codes and bit helpers for the page frame bitmap allocator.
// No dependencies.
`default_nettype none

package pfba_pkg;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_MARK    = 2'd3;

    localparam logic REG_HIGH_MEM = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    localparam int HIGH_MEM_W  = 19;
    localparam int RESERVED_W  = 17;
    localparam int FRAME_NUM_W = 16;
    localparam int ADDR_W      = 28;
    localparam int PAGE_SHIFT  = 12;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [FRAME_NUM_W-1:0] frame_number;
    } pfba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_addr;
        logic              found;
    } pfba_res_t;

    // Index of the lowest clear bit; only meaningful when the byte is not full.
    function automatic logic [2:0] lowest_zero(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

    // Mask with the lowest n bits set.
    function automatic logic [7:0] low_mask(input logic [2:0] n);
        logic [7:0] m;
        m = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < n) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/pfba_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module pfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/pfba_engine.sv */
// Command sequencer for the frame bitmap: clear pass, init sweep, first-fit scan
// and single-byte read-modify-write. Uses pfba_pkg and pfba_ram.
`default_nettype none

module pfba_engine
    import pfba_pkg::*;
#(
    parameter int MAX_FRAMES = 65536
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire pfba_req_t             req,
    input  wire logic [HIGH_MEM_W-1:0] high_mem_kb,
    input  wire logic [RESERVED_W-1:0] reserved_pages,
    input  wire logic                  res_take,
    output logic                       idle,
    output logic                       done,
    output pfba_res_t                  res
);

    localparam int MAP_BYTES  = MAX_FRAMES / 8;
    localparam int MAP_FRAMES = MAP_BYTES * 8;
    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] BYTES_C = CW'(MAP_BYTES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_WR    = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          hint_reg, hint_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [FRAME_NUM_W-1:0] frame_reg, frame_next;
    logic [CW-1:0]          free_bytes_reg, free_bytes_next;
    logic [CW-1:0]          rsv_full_reg, rsv_full_next;
    logic [2:0]             rsv_rem_reg, rsv_rem_next;
    pfba_res_t              res_reg, res_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;

    logic [31:0]            usable;
    logic [31:0]            rsv_limit;
    logic                   req_in_range;
    logic [AW-1:0]          frame_byte;
    logic [2:0]             frame_bit;
    logic [7:0]             sweep_byte;
    logic [2:0]             hit_bit;
    logic [31:0]            hit_frame;

    pfba_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        usable = 32'(high_mem_kb >> 2);
        if (usable > 32'(MAP_FRAMES))
        begin
            usable = 32'(MAP_FRAMES);
        end
        rsv_limit = 32'(reserved_pages);
        if (rsv_limit > 32'(MAP_FRAMES))
        begin
            rsv_limit = 32'(MAP_FRAMES);
        end
    end

    assign req_in_range = 32'(req.frame_number) < 32'(MAP_FRAMES);
    assign frame_byte   = AW'(32'(frame_reg) >> 3);
    assign frame_bit    = frame_reg[2:0];
    assign hit_bit      = lowest_zero(ram_rdata);
    assign hit_frame    = (32'(rd_addr_reg) << 3) | 32'(hit_bit);

    // Init value of the byte under the sweep pointer: free below the usable
    // limit, then the reserved frames forced used.
    always_comb
    begin
        sweep_byte = (ptr_reg < free_bytes_reg) ? 8'h00 : FULL_BYTE;
        if (ptr_reg < rsv_full_reg)
        begin
            sweep_byte = FULL_BYTE;
        end
        else if (ptr_reg == rsv_full_reg)
        begin
            sweep_byte = sweep_byte | low_mask(rsv_rem_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        hint_next       = hint_reg;
        rd_valid_next   = rd_valid_reg;
        rd_addr_next    = rd_addr_reg;
        cmd_next        = cmd_reg;
        frame_next      = frame_reg;
        free_bytes_next = free_bytes_reg;
        rsv_full_next   = rsv_full_reg;
        rsv_rem_next    = rsv_rem_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_addr        = ptr_reg[AW-1:0];
        ram_wdata       = FULL_BYTE;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + CW'(1);
                if (ptr_reg == BYTES_C - CW'(1))
                begin
                    hint_next  = BYTES_C;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = req.cmd;
                    frame_next      = req.frame_number;
                    res_next        = '0;
                    free_bytes_next = CW'(usable >> 3);
                    rsv_full_next   = CW'(rsv_limit >> 3);
                    rsv_rem_next    = rsv_limit[2:0];
                    ptr_next        = '0;
                    rd_valid_next   = 1'b0;
                    case (req.cmd)
                        CMD_INIT:
                        begin
                            state_next = ST_SWEEP;
                        end
                        CMD_ALLOC:
                        begin
                            ptr_next   = hint_reg;
                            state_next = (hint_reg == BYTES_C) ? ST_DONE : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = req_in_range ? ST_RD : ST_DONE;
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_wdata = sweep_byte;
                ptr_next  = ptr_reg + CW'(1);
                if (ptr_reg == BYTES_C - CW'(1))
                begin
                    hint_next  = '0;
                    state_next = ST_DONE;
                end
            end

            ST_SCAN:
            begin
                if (rd_valid_reg && ram_rdata != FULL_BYTE)
                begin
                    ram_we              = 1'b1;
                    ram_addr            = rd_addr_reg;
                    ram_wdata           = ram_rdata | (8'd1 << hit_bit);
                    hint_next           = CW'(rd_addr_reg);
                    res_next.found      = 1'b1;
                    res_next.frame_addr = ADDR_W'({hit_frame, PAGE_SHIFT'(0)});
                    state_next          = ST_DONE;
                end
                else if (ptr_reg != BYTES_C)
                begin
                    // One read issued per cycle; data for rd_addr arrives next cycle.
                    rd_addr_next  = ptr_reg[AW-1:0];
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + CW'(1);
                end
                else if (rd_valid_reg)
                begin
                    rd_valid_next = 1'b0;
                end
                else
                begin
                    hint_next  = BYTES_C;
                    state_next = ST_DONE;
                end
            end

            ST_RD:
            begin
                ram_addr   = frame_byte;
                state_next = ST_WR;
            end

            ST_WR:
            begin
                ram_we   = 1'b1;
                ram_addr = frame_byte;
                if (cmd_reg == CMD_RELEASE)
                begin
                    ram_wdata = ram_rdata & ~(8'd1 << frame_bit);
                    if (CW'(frame_byte) < hint_reg)
                    begin
                        hint_next = CW'(frame_byte);
                    end
                end
                else
                begin
                    ram_wdata = ram_rdata | (8'd1 << frame_bit);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            hint_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            hint_reg     <= hint_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        cmd_reg        <= cmd_next;
        frame_reg      <= frame_next;
        free_bytes_reg <= free_bytes_next;
        rsv_full_reg   <= rsv_full_next;
        rsv_rem_reg    <= rsv_rem_next;
        res_reg        <= res_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign res  = res_reg;

endmodule

`default_nettype wire

/* rtl/page_frame_bitmap_allocator.sv */
// Top level of the page frame bitmap allocator: stream ports, configuration
// registers and output register. Uses pfba_pkg, pfba_engine and the assert macros.
//
// Usage: each input word carries a command in s_tuser and a frame number in
// s_tdata; every command returns exactly one output word. Allocate returns
// the frame's physical address in m_tdata and found in m_tuser; all other
// commands, and an allocate on a full map, return zero with found low.
// Registers high_mem_kb (index 0) and reserved_pages (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// command is in flight, and the block itself does not enforce this.
// An allocate reads map bytes from the search hint (lowest byte that may
// hold a free frame) up to the first non-full byte, and returns without a
// scan when the map is already known full. One map byte is read per cycle
// on the single RAM port.
// Commands are handled one at a time; s_tready is high only while the
// sequencer is idle, so with the output free the next word can be accepted
// in the same cycle that the result appears.
// Reset: the map is written all-used in a clearing pass over all MAP_BYTES
// bytes (8192 at the default size), during which s_tready stays low.
// A finished result waits in the output register while m_tready is low, and
// one further command may be accepted and processed meanwhile; its result
// then holds in the sequencer until the output register frees up.
`default_nettype none

module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int MAX_FRAMES = 65536
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] frame_number
    input  wire logic [1:0]            s_tuser,   // [1:0] cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [27:0] frame_addr, [31:28] zero
    output logic                       m_tuser,   // [0] found
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [HIGH_MEM_W-1:0] cfg_data
);

    logic [HIGH_MEM_W-1:0] high_mem_kb_reg;
    logic [RESERVED_W-1:0] reserved_pages_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    pfba_res_t             out_reg;

    pfba_req_t             req;
    pfba_res_t             eng_res;
    logic                  eng_idle;
    logic                  eng_done;
    logic                  out_free;
    logic                  accept;

    assign req.cmd          = s_tuser;
    assign req.frame_number = s_tdata;

    assign s_tready = eng_idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    pfba_engine #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (accept),
        .req            (req),
        .high_mem_kb    (high_mem_kb_reg),
        .reserved_pages (reserved_pages_reg),
        .res_take       (out_free),
        .idle           (eng_idle),
        .done           (eng_done),
        .res            (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_mem_kb_reg    <= '0;
            reserved_pages_reg <= RESERVED_W'(2048);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIGH_MEM: high_mem_kb_reg    <= cfg_data;
                REG_RESERVED: reserved_pages_reg <= cfg_data[RESERVED_W-1:0];
                default:      high_mem_kb_reg    <= high_mem_kb_reg;
            endcase
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (eng_done && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done && out_free)
        begin
            out_reg <= eng_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 32'(out_reg.frame_addr);
    assign m_tuser  = out_reg.found;

`include "page_frame_bitmap_allocator_assert.svh"

    `PFBA_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "accepted a word while busy")
    `PFBA_ASSERT_NEXT(a_result_held, eng_done && !out_free, eng_done, "pending result dropped")
    `PFBA_ASSERT_NOW(a_notfound_zero, m_tvalid && !m_tuser, m_tdata == 32'd0, "nonzero address without found")
    `PFBA_ASSERT_NOW(a_page_aligned, m_tvalid, m_tdata[11:0] == 12'd0, "address not page aligned")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for page_frame_bitmap_allocator: it drives command words
// and keeps its own copy of the frame bitmap to predict and check every result word.
// Depends on pfba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
    import pfba_pkg::*;

    localparam int MAX_FRAMES = 65536;
    localparam int MAP_BYTES  = MAX_FRAMES / 8;
    localparam int MAP_FRAMES = MAP_BYTES * 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic [1:0]            s_tuser = CMD_INIT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_HIGH_MEM;
    logic [HIGH_MEM_W-1:0] cfg_data = '0;

    // Shadow copy of the allocator state and its registers.
    logic [7:0]            shadow_map [MAP_BYTES];
    logic [HIGH_MEM_W-1:0] mem_kb_cfg;
    logic [RESERVED_W-1:0] reserve_cfg;
    int                    free_frames;
    int                    alloc_frames[$];

    pfba_res_t             pending_results[$];
    int                    error_count = 0;
    bit                    src_idle_on = 1'b1;
    bit                    sink_idle_on = 1'b1;
    int                    stall_request = 0;

    page_frame_bitmap_allocator #(
        .MAX_FRAMES(MAX_FRAMES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int usable_frames();
        int usable;
        usable = int'(mem_kb_cfg) / 4;
        if (usable > MAP_FRAMES)
            usable = MAP_FRAMES;
        return usable;
    endfunction

    function automatic void touch_frame(input int f, input logic used);
        if (f < MAP_FRAMES && shadow_map[f >> 3][f & 7] != used)
        begin
            shadow_map[f >> 3][f & 7] = used;
            free_frames += used ? -1 : 1;
        end
    endfunction

    function automatic void rebuild_map();
        int free_bytes;
        int limit;
        free_bytes = usable_frames() / 8;
        for (int i = 0; i < MAP_BYTES; i++)
            shadow_map[i] = (i < free_bytes) ? 8'h00 : FULL_BYTE;
        free_frames = free_bytes * 8;
        limit = int'(reserve_cfg);
        if (limit > MAP_FRAMES)
            limit = MAP_FRAMES;
        for (int i = 0; i < limit; i++)
            touch_frame(i, 1'b1);
        alloc_frames.delete();
    endfunction

    function automatic int first_free_frame();
        for (int i = 0; i < MAP_BYTES; i++)
        begin
            if (shadow_map[i] != FULL_BYTE)
            begin
                for (int b = 0; b < 8; b++)
                begin
                    if (!shadow_map[i][b])
                        return i * 8 + b;
                end
            end
        end
        return -1;
    endfunction

    // Applies one command to the shadow state and returns the word it should produce.
    function automatic pfba_res_t predict_cmd(input logic [1:0] cmd, input logic [15:0] frame);
        pfba_res_t res;
        int f;
        res = '0;
        case (cmd)
            CMD_INIT:
                rebuild_map();
            CMD_ALLOC:
            begin
                f = first_free_frame();
                if (f >= 0)
                begin
                    touch_frame(f, 1'b1);
                    res.frame_addr = ADDR_W'(f) << PAGE_SHIFT;
                    res.found = 1'b1;
                    alloc_frames.push_back(f);
                end
            end
            CMD_RELEASE:
                touch_frame(int'(frame), 1'b0);
            default:
                touch_frame(int'(frame), 1'b1);
        endcase
        return res;
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [15:0] frame);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 99) < 35)
            gap = idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= frame;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_cmd(cmd, frame));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Registers are only written with nothing in flight.
    task automatic write_regs(input logic [HIGH_MEM_W-1:0] mem_kb,
                              input logic [RESERVED_W-1:0] reserve);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_HIGH_MEM;
        cfg_data  <= mem_kb;
        @(posedge clk);
        cfg_index <= REG_RESERVED;
        cfg_data  <= HIGH_MEM_W'(reserve);
        @(posedge clk);
        cfg_we <= 1'b0;
        mem_kb_cfg  = mem_kb;
        reserve_cfg = reserve;
    endtask

    task automatic test_reset_state();
        // Every frame is used after reset, so the first allocate finds nothing.
        send_word(CMD_ALLOC, 16'hFFFF);
        send_word(CMD_RELEASE, 16'd0);
        send_word(CMD_ALLOC, 16'd0);
        send_word(CMD_MARK, 16'hFFFF);
        send_word(CMD_RELEASE, 16'hFFFF);
        send_word(CMD_ALLOC, 16'h5A5A);
        // No installed memory: init leaves the map full.
        send_word(CMD_INIT, 16'hFFFF);
        send_word(CMD_ALLOC, 16'd0);
    endtask

    task automatic test_config_extremes();
        write_regs(19'd262144, 17'd0);
        send_word(CMD_INIT, 16'h1234);
        send_word(CMD_ALLOC, 16'd0);
        send_word(CMD_ALLOC, 16'd0);
        send_word(CMD_RELEASE, 16'd0);
        send_word(CMD_ALLOC, 16'd0);
        send_word(CMD_MARK, 16'd2);
        send_word(CMD_ALLOC, 16'd0);
        // Installed memory and reservation beyond the map are both capped.
        write_regs(19'h7FFFF, 17'h1FFFF);
        send_word(CMD_INIT, 16'd0);
        send_word(CMD_ALLOC, 16'd0);
        // Thirteen usable frames: the partial last byte stays used.
        write_regs(19'd52, 17'd3);
        send_word(CMD_INIT, 16'd0);
        repeat (6) send_word(CMD_ALLOC, 16'd0);
        // Only the top frame is left free, giving the highest address.
        write_regs(19'd262144, 17'd65535);
        send_word(CMD_INIT, 16'd0);
        send_word(CMD_ALLOC, 16'd0);
        send_word(CMD_ALLOC, 16'd0);
    endtask

    task automatic test_back_pressure();
        write_regs(19'd4096, 17'd16);
        send_word(CMD_INIT, 16'd0);
        drain_results();
        src_idle_on   = 1'b0;
        stall_request = 400;
        repeat (10) send_word(CMD_ALLOC, 16'($urandom));
        src_idle_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_traffic();
        int r;
        int span;
        int pick;
        int f;
        int full_allocs;
        logic [HIGH_MEM_W-1:0] mem_kb;
        logic [RESERVED_W-1:0] reserve;
        full_allocs = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 3))
                0: mem_kb = HIGH_MEM_W'($urandom_range(0, 262144));
                1: mem_kb = HIGH_MEM_W'($urandom_range(0, 19'h7FFFF));
                2: mem_kb = HIGH_MEM_W'($urandom_range(0, 8192));
                default: mem_kb = 19'd262144;
            endcase
            r = $urandom_range(0, 99);
            if (r < 70)
                reserve = RESERVED_W'($urandom_range(0, 4096));
            else if (r < 85)
                reserve = RESERVED_W'($urandom_range(0, 65536));
            else
                reserve = RESERVED_W'($urandom_range(0, 17'h1FFFF));
            write_regs(mem_kb, reserve);
            src_idle_on  = ($urandom_range(0, 4) != 0);
            sink_idle_on = ($urandom_range(0, 4) != 0);
            send_word(CMD_INIT, 16'($urandom));
            for (int n = 0; n < 165; n++)
            begin
                span = usable_frames();
                if (span == 0)
                    span = 256;
                r = $urandom_range(0, 99);
                // An allocate on a full map can scan up to every byte, so keep those rare.
                if (r < 55 && (free_frames > 0 || full_allocs < 16))
                begin
                    if (free_frames == 0)
                        full_allocs++;
                    send_word(CMD_ALLOC, 16'($urandom));
                end
                else if (r < 85)
                begin
                    if (alloc_frames.size() > 0)
                    begin
                        pick = $urandom_range(0, alloc_frames.size() - 1);
                        f = alloc_frames[pick];
                        alloc_frames.delete(pick);
                        send_word(CMD_RELEASE, 16'(f));
                    end
                    else
                        send_word(CMD_RELEASE, 16'($urandom_range(0, span - 1)));
                end
                else if (r < 95)
                    send_word(CMD_MARK, 16'($urandom_range(0, span - 1)));
                else if (r < 99)
                    send_word(r[0] ? CMD_RELEASE : CMD_MARK, 16'($urandom));
                else
                    send_word(CMD_INIT, 16'($urandom));
            end
        end
    endtask

    // Result checker and receiver pacing share one process.
    initial
    begin
        pfba_res_t want;
        int ready_hold_left;
        ready_hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word: frame_addr %0h found %0b",
                           m_tdata[27:0], m_tuser);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[27:0] !== want.frame_addr)
                    begin
                        $error("frame_addr: expected %0h, actual %0h",
                               want.frame_addr, m_tdata[27:0]);
                        error_count++;
                    end
                    if (m_tuser !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, m_tuser);
                        error_count++;
                    end
                end
            end
            if (stall_request > 0)
            begin
                ready_hold_left = stall_request;
                stall_request = 0;
            end
            if (ready_hold_left == 0 && sink_idle_on && $urandom_range(0, 99) < 25)
                ready_hold_left = idle_length();
            if (ready_hold_left > 0)
            begin
                ready_hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        for (int i = 0; i < MAP_BYTES; i++)
            shadow_map[i] = FULL_BYTE;
        mem_kb_cfg  = '0;
        reserve_cfg = RESERVED_W'(2048);
        free_frames = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_config_extremes();
        test_back_pressure();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/pfba_pkg.sv
rtl/pfba_ram.sv
rtl/pfba_engine.sv
rtl/page_frame_bitmap_allocator.sv
dv/testbench.sv
